### rtl/ycs_pkg.sv
// Shared widths, codes, item type and the tau classifier for the Svensson curve evaluator.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package ycs_pkg;

   localparam int WORD_BITS    = 32;
   localparam int FRAC_BITS    = 24;
   localparam int INT_FRAC     = 31;                 // internal Q1.31 loadings
   localparam int Q_BITS       = INT_FRAC + 1;       // holds 0 .. 1.0 inclusive
   localparam int X_CAP_SHIFT  = 5;                  // ratio cap is 2^5 = 32
   localparam int XQ_BITS      = FRAC_BITS + X_CAP_SHIFT;
   localparam int N_BITS       = X_CAP_SHIFT;
   localparam int SERIES_TERMS = 17;
   localparam int POW_STAGES   = (1 << X_CAP_SHIFT) - 1;
   localparam int ACC_BITS     = Q_BITS + 2;
   localparam int RECIP_BITS   = Q_BITS + 1;
   localparam int CSR_IDX_BITS = 3;
   localparam int QUEUE_DEPTH  = 2;                  // power of two
   localparam int QPTR_BITS    = 1;
   localparam int QCNT_BITS    = QPTR_BITS + 1;

   localparam logic [Q_BITS-1:0]   ONE_Q = {1'b1, {INT_FRAC{1'b0}}};
   // exp(-1) from the truncated 17-term series in Q31
   localparam logic [INT_FRAC-1:0] E1_Q  = INT_FRAC'(790015085);
   localparam logic [WORD_BITS-1:0] DECAY_RESET =
      {{(WORD_BITS-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_LEVEL  = 3'd0,
      CSR_SLOPE  = 3'd1,
      CSR_HUMP   = 3'd2,
      CSR_HUMP2  = 3'd3,
      CSR_DECAY1 = 3'd4,
      CSR_DECAY2 = 3'd5
   } csr_idx_type;

   typedef enum logic [1:0] {
      KIND_NORMAL,     // t < 32*tau, full exp and divide
      KIND_CAP,        // t >= 32*tau, exp taken as 0
      KIND_ZERO_TAU,   // tau is zero, both loadings 0
      KIND_UNIT        // ratio truncates to 0, both loadings 1.0
   } kind_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] maturity;
      kind_type             kind_one;
      kind_type             kind_two;
   } item_type;

   function automatic kind_type classify(input logic [WORD_BITS-1:0] t,
                                         input logic [WORD_BITS-1:0] tau);
      kind_type k;
      if (tau == '0) begin
         k = KIND_ZERO_TAU;
      end else if ({{X_CAP_SHIFT{1'b0}}, t} >= {tau, {X_CAP_SHIFT{1'b0}}}) begin
         k = KIND_CAP;
      end else begin
         k = KIND_NORMAL;
      end
      return k;
   endfunction

endpackage

### rtl/ycs_front.sv
// Front end: takes a maturity beat on start/busy and classifies it against both taus.
// Depends on ycs_pkg; feeds ycs_queue.
module ycs_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ycs_pkg::WORD_BITS-1:0]  req_maturity,
   input  logic [ycs_pkg::WORD_BITS-1:0]  decay_one,
   input  logic [ycs_pkg::WORD_BITS-1:0]  decay_two,
   input  logic                           push_ready,
   output logic                           busy,
   output logic                           push_valid,
   output ycs_pkg::item_type              push_item
);

   logic              front_valid_ff, front_valid_in;
   ycs_pkg::item_type front_item_ff, front_item_in;
   logic              accept;

   assign busy   = front_valid_ff && !push_ready;
   assign accept = start && !busy;

   always_comb begin
      front_valid_in = front_valid_ff && !push_ready;
      front_item_in  = front_item_ff;
      if (accept) begin
         front_valid_in         = 1'b1;
         front_item_in.maturity = req_maturity;
         front_item_in.kind_one = ycs_pkg::classify(req_maturity, decay_one);
         front_item_in.kind_two = ycs_pkg::classify(req_maturity, decay_two);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_item_ff <= front_item_in;
   end

   assign push_valid = front_valid_ff;
   assign push_item  = front_item_ff;

endmodule

### rtl/ycs_queue.sv
// Short queue between the classifier and the evaluation pipes; drains a beat every cycle.
// Depends on ycs_pkg.
module ycs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  ycs_pkg::item_type push_item,
   output logic              push_ready,
   output logic              pop_valid,
   output ycs_pkg::item_type pop_item
);

   ycs_pkg::item_type                  slot_ff [ycs_pkg::QUEUE_DEPTH];
   logic [ycs_pkg::QPTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [ycs_pkg::QPTR_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [ycs_pkg::QCNT_BITS-1:0]      count_ff, count_in;
   logic                               push, pop;

   assign push_ready = count_ff != ycs_pkg::QCNT_BITS'(ycs_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + ycs_pkg::QCNT_BITS'(push) - ycs_pkg::QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   // the back end pops every cycle, so the queue never fills
   a_never_full: assert property (@(posedge clock) disable iff (reset)
      count_ff != ycs_pkg::QCNT_BITS'(ycs_pkg::QUEUE_DEPTH))
      else $error("ycs_queue: queue filled although drained each cycle");

endmodule

### rtl/ycs_lane.sv
// One tau lane: ratio divide, exp(-frac) series, exp(-1) powers, loading divide.
// Depends on ycs_pkg; two instances sit in the top level.
module ycs_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  ycs_pkg::kind_type             in_kind,
   input  logic [ycs_pkg::WORD_BITS-1:0] in_t,
   input  logic [ycs_pkg::WORD_BITS-1:0] in_tau,
   output logic                          out_valid,
   output logic [ycs_pkg::Q_BITS-1:0]    out_e,
   output logic [ycs_pkg::Q_BITS-1:0]    out_g
);

   localparam int W      = ycs_pkg::WORD_BITS;
   localparam int QB     = ycs_pkg::Q_BITS;
   localparam int XB     = ycs_pkg::XQ_BITS;
   localparam int FB     = ycs_pkg::FRAC_BITS;
   localparam int IF     = ycs_pkg::INT_FRAC;
   localparam int AB     = ycs_pkg::ACC_BITS;
   localparam int RB     = ycs_pkg::RECIP_BITS;
   localparam int D1     = XB;
   localparam int DIV1_W = W + IF;
   localparam int D2     = QB;
   localparam int DIV2_W = QB + FB;
   localparam int NS     = ycs_pkg::SERIES_TERMS - 1;
   localparam int SR     = 3 * NS;
   localparam int PW     = ycs_pkg::POW_STAGES;
   localparam int CL     = SR + 1;
   localparam int WK_N   = SR + PW + 2;

   typedef struct packed {
      ycs_pkg::kind_type           kind;
      logic [XB-1:0]               xq;
      logic [ycs_pkg::N_BITS-1:0]  n;
      logic [IF-1:0]               f;
      logic [QB-1:0]               term;
      logic [QB-1:0]               prod;
      logic signed [AB-1:0]        acc;
      logic [QB-1:0]               e;
      logic [QB-1:0]               g;
   } work_type;

   // reciprocal constants floor(2^QB / k) for the series divides
   logic [RB-1:0] recip [NS];
   for (genvar gk = 0; gk < NS; gk++) begin : g_recip
      localparam int K = gk + 1;
      localparam logic [RB-1:0] RECIP = RB'((65'd1 << QB) / K);
      assign recip[gk] = RECIP;
   end

   // ---- ratio divider ----
   logic [D1:0]              d1_v_ff;
   ycs_pkg::kind_type        d1_kind_ff [D1+1], d1_kind_in [D1+1];
   logic [W-1:0]             d1_rem_ff  [D1+1], d1_rem_in  [D1+1];
   logic [W-1:0]             d1_den_ff  [D1+1], d1_den_in  [D1+1];
   logic [D1-1:0]            d1_low_ff  [D1+1], d1_low_in  [D1+1];
   logic [D1-1:0]            d1_quo_ff  [D1+1], d1_quo_in  [D1+1];

   // ---- series / clamp / power ----
   logic [WK_N-1:0]          wk_v_ff;
   work_type                 wk_ff [WK_N], wk_in [WK_N];

   // ---- loading divider ----
   logic [D2:0]              d2_v_ff;
   work_type                 d2_wk_ff  [D2+1], d2_wk_in  [D2+1];
   logic [XB-1:0]            d2_rem_ff [D2+1], d2_rem_in [D2+1];
   logic [D2-1:0]            d2_low_ff [D2+1], d2_low_in [D2+1];
   logic [D2-1:0]            d2_quo_ff [D2+1], d2_quo_in [D2+1];
   logic                     d2_ovf_ff [D2+1], d2_ovf_in [D2+1];

   logic                     out_valid_ff;
   logic [QB-1:0]            out_e_ff, out_e_in, out_g_ff, out_g_in;

   // ratio divider: t*2^FB/tau, or tau*2^IF/t in the capped case
   always_comb begin
      logic [DIV1_W-1:0] num;
      logic [W:0]        r;
      logic              qb;
      if (in_kind == ycs_pkg::KIND_CAP) begin
         num = {in_tau, {IF{1'b0}}};
      end else begin
         num = DIV1_W'({in_t, {FB{1'b0}}});
      end
      d1_kind_in[0] = in_kind;
      d1_rem_in[0]  = W'(num >> D1);
      d1_low_in[0]  = num[D1-1:0];
      d1_quo_in[0]  = '0;
      d1_den_in[0]  = (in_kind == ycs_pkg::KIND_CAP) ? in_t : in_tau;
      for (int j = 1; j <= D1; j++) begin
         r = {d1_rem_ff[j-1], d1_low_ff[j-1][D1-1]};
         if (r >= {1'b0, d1_den_ff[j-1]}) begin
            d1_rem_in[j] = W'(r - {1'b0, d1_den_ff[j-1]});
            qb = 1'b1;
         end else begin
            d1_rem_in[j] = r[W-1:0];
            qb = 1'b0;
         end
         d1_low_in[j]  = d1_low_ff[j-1] << 1;
         d1_quo_in[j]  = {d1_quo_ff[j-1][D1-2:0], qb};
         d1_den_in[j]  = d1_den_ff[j-1];
         d1_kind_in[j] = d1_kind_ff[j-1];
      end
   end

   // work pipe: sort out special kinds, series terms, clamp, powers of exp(-1)
   always_comb begin
      logic [D1-1:0]      quo;
      logic [2*QB-1:0]    mprod;
      logic [QB+RB-1:0]   rprod;
      logic [QB-1:0]      kprod;
      logic [QB-1:0]      rem;
      logic [QB-1:0]      tnew;
      int                 b;
      quo = d1_quo_ff[D1];
      wk_in[0].kind = d1_kind_ff[D1];
      if (d1_kind_ff[D1] == ycs_pkg::KIND_NORMAL && quo == '0) begin
         wk_in[0].kind = ycs_pkg::KIND_UNIT;
      end
      wk_in[0].xq   = quo;
      wk_in[0].n    = quo[D1-1:FB];
      wk_in[0].f    = {quo[FB-1:0], {(IF-FB){1'b0}}};
      wk_in[0].term = ycs_pkg::ONE_Q;
      wk_in[0].prod = '0;
      wk_in[0].acc  = $signed({2'b00, ycs_pkg::ONE_Q});
      unique case (wk_in[0].kind)
         ycs_pkg::KIND_CAP: begin
            wk_in[0].e = '0;
            wk_in[0].g = QB'(quo);
         end
         ycs_pkg::KIND_UNIT: begin
            wk_in[0].e = ycs_pkg::ONE_Q;
            wk_in[0].g = ycs_pkg::ONE_Q;
         end
         default: begin
            wk_in[0].e = '0;
            wk_in[0].g = '0;
         end
      endcase

      for (int k = 1; k <= NS; k++) begin
         b = 3 * (k - 1);
         // term times fraction
         wk_in[b+1] = wk_ff[b];
         mprod = {{QB{1'b0}}, wk_ff[b].term} * {{(QB+1){1'b0}}, wk_ff[b].f};
         wk_in[b+1].prod = mprod[IF +: QB];
         // estimate of prod / k, low by at most one
         wk_in[b+2] = wk_ff[b+1];
         rprod = {{RB{1'b0}}, wk_ff[b+1].prod} * {{QB{1'b0}}, recip[k-1]};
         wk_in[b+2].term = rprod[QB +: QB];
         // correct and accumulate with alternating sign
         wk_in[b+3] = wk_ff[b+2];
         kprod = wk_ff[b+2].term * QB'(k);
         rem   = wk_ff[b+2].prod - kprod;
         tnew  = (rem >= QB'(k)) ? wk_ff[b+2].term + 1'b1 : wk_ff[b+2].term;
         wk_in[b+3].term = tnew;
         if (k % 2 == 1) begin
            wk_in[b+3].acc = wk_ff[b+2].acc - $signed({2'b00, tnew});
         end else begin
            wk_in[b+3].acc = wk_ff[b+2].acc + $signed({2'b00, tnew});
         end
      end

      wk_in[CL] = wk_ff[CL-1];
      if (wk_ff[CL-1].kind == ycs_pkg::KIND_NORMAL) begin
         if (wk_ff[CL-1].acc < 0) begin
            wk_in[CL].e = '0;
         end else if (wk_ff[CL-1].acc > $signed({2'b00, ycs_pkg::ONE_Q})) begin
            wk_in[CL].e = ycs_pkg::ONE_Q;
         end else begin
            wk_in[CL].e = wk_ff[CL-1].acc[QB-1:0];
         end
      end

      for (int i = 0; i < PW; i++) begin
         wk_in[CL+1+i] = wk_ff[CL+i];
         mprod = {{QB{1'b0}}, wk_ff[CL+i].e} * {{(QB+1){1'b0}}, ycs_pkg::E1_Q};
         if (wk_ff[CL+i].kind == ycs_pkg::KIND_NORMAL &&
             ycs_pkg::N_BITS'(i) < wk_ff[CL+i].n) begin
            wk_in[CL+1+i].e = mprod[IF +: QB];
         end
      end
   end

   // loading divider: (1 - e)*2^FB / xq, with overflow flagged up front
   always_comb begin
      logic [DIV2_W-1:0] num;
      logic [XB-1:0]     head;
      logic [XB:0]       r;
      logic              qb;
      num  = {ycs_pkg::ONE_Q - wk_ff[WK_N-1].e, {FB{1'b0}}};
      head = XB'(num >> D2);
      d2_wk_in[0]  = wk_ff[WK_N-1];
      d2_ovf_in[0] = head >= wk_ff[WK_N-1].xq;
      d2_rem_in[0] = d2_ovf_in[0] ? '0 : head;
      d2_low_in[0] = num[D2-1:0];
      d2_quo_in[0] = '0;
      for (int j = 1; j <= D2; j++) begin
         r = {d2_rem_ff[j-1], d2_low_ff[j-1][D2-1]};
         if (r >= {1'b0, d2_wk_ff[j-1].xq}) begin
            d2_rem_in[j] = XB'(r - {1'b0, d2_wk_ff[j-1].xq});
            qb = 1'b1;
         end else begin
            d2_rem_in[j] = r[XB-1:0];
            qb = 1'b0;
         end
         d2_low_in[j] = d2_low_ff[j-1] << 1;
         d2_quo_in[j] = {d2_quo_ff[j-1][D2-2:0], qb};
         d2_ovf_in[j] = d2_ovf_ff[j-1];
         d2_wk_in[j]  = d2_wk_ff[j-1];
      end
      out_e_in = d2_wk_ff[D2].e;
      out_g_in = d2_wk_ff[D2].g;
      if (d2_wk_ff[D2].kind == ycs_pkg::KIND_NORMAL) begin
         if (d2_ovf_ff[D2] || d2_quo_ff[D2] > ycs_pkg::ONE_Q) begin
            out_g_in = ycs_pkg::ONE_Q;
         end else begin
            out_g_in = d2_quo_ff[D2];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_v_ff      <= '0;
         wk_v_ff      <= '0;
         d2_v_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         d1_v_ff      <= {d1_v_ff[D1-1:0], in_valid};
         wk_v_ff      <= {wk_v_ff[WK_N-2:0], d1_v_ff[D1]};
         d2_v_ff      <= {d2_v_ff[D2-1:0], wk_v_ff[WK_N-1]};
         out_valid_ff <= d2_v_ff[D2];
      end
   end

   always_ff @(posedge clock) begin
      d1_kind_ff <= d1_kind_in;
      d1_rem_ff  <= d1_rem_in;
      d1_den_ff  <= d1_den_in;
      d1_low_ff  <= d1_low_in;
      d1_quo_ff  <= d1_quo_in;
      wk_ff      <= wk_in;
      d2_wk_ff   <= d2_wk_in;
      d2_rem_ff  <= d2_rem_in;
      d2_low_ff  <= d2_low_in;
      d2_quo_ff  <= d2_quo_in;
      d2_ovf_ff  <= d2_ovf_in;
      out_e_ff   <= out_e_in;
      out_g_ff   <= out_g_in;
   end

   assign out_valid = out_valid_ff;
   assign out_e     = out_e_ff;
   assign out_g     = out_g_ff;

   a_e_le_one: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_e <= ycs_pkg::ONE_Q)
      else $error("ycs_lane: decay above 1.0");

   a_g_le_one: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_g <= ycs_pkg::ONE_Q)
      else $error("ycs_lane: loading above 1.0");

endmodule

### rtl/yield_curve_svensson_eval_top.sv
// Top level of the Svensson yield-curve evaluator: CSRs, front end, queue, two tau lanes
// and the beta weighting / saturation back end. Depends on ycs_pkg and all rtl/ycs_* modules.
//
// Usage: one maturity beat (unsigned Q8.24) is taken on any cycle where start is high and
// busy is low; busy stays low in normal operation, so one maturity per clock is sustained.
// Each beat gives exactly one result, in order: rsp_valid pulses for one cycle with rsp_rate
// (signed Q8.24) and rsp_saturated. The receiver cannot stall, so results must be sampled
// when rsp_valid is high. The latency is set by the pipelined 29-step ratio divider, the
// 16-term exp series (three stages a term), the 31 stages of exp(-1) powers and the 32-step
// loading divider in each tau lane; both lanes run side by side. CSRs (index 0..5:
// beta0..beta3, tau1, tau2) are written through csr_valid/csr_ready, which is always ready;
// other indices are ignored. Write them only while no beat is in flight. A zero tau forces
// both its loadings to zero; zero maturity gives beta0 + beta1.
module yield_curve_svensson_eval_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [ycs_pkg::WORD_BITS-1:0]        req_maturity,
   output logic                                 rsp_valid,
   output logic signed [ycs_pkg::WORD_BITS-1:0] rsp_rate,
   output logic                                 rsp_saturated,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ycs_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [ycs_pkg::WORD_BITS-1:0]        csr_wdata
);

   localparam int W     = ycs_pkg::WORD_BITS;
   localparam int QB    = ycs_pkg::Q_BITS;
   localparam int SUM_W = W + 3;
   localparam logic signed [W-1:0] RATE_MAX = $signed({1'b0, {(W-1){1'b1}}});
   localparam logic signed [W-1:0] RATE_MIN = $signed({1'b1, {(W-1){1'b0}}});

   // configuration registers
   logic signed [W-1:0] level_beta_ff, slope_beta_ff, hump_beta_ff, second_hump_beta_ff;
   logic [W-1:0]        decay_one_ff, decay_two_ff;

   // front end to queue to lanes
   logic              push_valid, push_ready, pop_valid;
   ycs_pkg::item_type push_item, pop_item;

   logic              l1_valid, l2_valid;
   logic [QB-1:0]     l1_e, l1_g, l2_e, l2_g;

   // back-end stages
   logic              c0_valid_ff, c1_valid_ff, c2_valid_ff, rsp_valid_ff;
   logic [QB-1:0]     f_slope_ff, f_hump_ff, f_hump2_ff;
   logic [W-1:0]      p_slope_ff, p_hump_ff, p_hump2_ff;
   logic [W-1:0]      p_slope_in, p_hump_in, p_hump2_in;
   logic              n_slope_ff, n_hump_ff, n_hump2_ff;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [W-1:0]     rate_ff, rate_in;
   logic              sat_ff, sat_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_beta_ff       <= '0;
         slope_beta_ff       <= '0;
         hump_beta_ff        <= '0;
         second_hump_beta_ff <= '0;
         decay_one_ff        <= ycs_pkg::DECAY_RESET;
         decay_two_ff        <= ycs_pkg::DECAY_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ycs_pkg::CSR_LEVEL:  level_beta_ff       <= $signed(csr_wdata);
            ycs_pkg::CSR_SLOPE:  slope_beta_ff       <= $signed(csr_wdata);
            ycs_pkg::CSR_HUMP:   hump_beta_ff        <= $signed(csr_wdata);
            ycs_pkg::CSR_HUMP2:  second_hump_beta_ff <= $signed(csr_wdata);
            ycs_pkg::CSR_DECAY1: decay_one_ff        <= csr_wdata;
            ycs_pkg::CSR_DECAY2: decay_two_ff        <= csr_wdata;
            default: ;
         endcase
      end
   end

   ycs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_maturity (req_maturity),
      .decay_one    (decay_one_ff),
      .decay_two    (decay_two_ff),
      .push_ready   (push_ready),
      .busy         (busy),
      .push_valid   (push_valid),
      .push_item    (push_item)
   );

   ycs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item)
   );

   ycs_lane u_lane_one (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pop_valid),
      .in_kind   (pop_item.kind_one),
      .in_t      (pop_item.maturity),
      .in_tau    (decay_one_ff),
      .out_valid (l1_valid),
      .out_e     (l1_e),
      .out_g     (l1_g)
   );

   ycs_lane u_lane_two (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pop_valid),
      .in_kind   (pop_item.kind_two),
      .in_t      (pop_item.maturity),
      .in_tau    (decay_two_ff),
      .out_valid (l2_valid),
      .out_e     (l2_e),
      .out_g     (l2_g)
   );

   // |beta| * loading / 2^31, truncated; loading <= 1.0 so the result fits a word
   function automatic logic [W-1:0] scale_mag(input logic signed [W-1:0] beta,
                                              input logic [QB-1:0] f);
      logic [W-1:0]    mag;
      logic [W+QB-1:0] prod;
      mag  = beta[W-1] ? W'(-beta) : beta;
      prod = {{QB{1'b0}}, mag} * {{W{1'b0}}, f};
      return prod[ycs_pkg::INT_FRAC +: W];
   endfunction

   always_comb begin
      p_slope_in = scale_mag(slope_beta_ff, f_slope_ff);
      p_hump_in  = scale_mag(hump_beta_ff, f_hump_ff);
      p_hump2_in = scale_mag(second_hump_beta_ff, f_hump2_ff);

      sum_in = SUM_W'(level_beta_ff)
             + (n_slope_ff ? -$signed({3'b000, p_slope_ff}) : $signed({3'b000, p_slope_ff}))
             + (n_hump_ff  ? -$signed({3'b000, p_hump_ff})  : $signed({3'b000, p_hump_ff}))
             + (n_hump2_ff ? -$signed({3'b000, p_hump2_ff}) : $signed({3'b000, p_hump2_ff}));

      if (sum_ff > SUM_W'(RATE_MAX)) begin
         rate_in = RATE_MAX;
         sat_in  = 1'b1;
      end else if (sum_ff < SUM_W'(RATE_MIN)) begin
         rate_in = RATE_MIN;
         sat_in  = 1'b1;
      end else begin
         rate_in = sum_ff[W-1:0];
         sat_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c0_valid_ff  <= 1'b0;
         c1_valid_ff  <= 1'b0;
         c2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         c0_valid_ff  <= l1_valid && l2_valid;
         c1_valid_ff  <= c0_valid_ff;
         c2_valid_ff  <= c1_valid_ff;
         rsp_valid_ff <= c2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      // loadings: slope, then curvature terms clamped at zero
      f_slope_ff <= l1_g;
      f_hump_ff  <= (l1_g > l1_e) ? l1_g - l1_e : '0;
      f_hump2_ff <= (l2_g > l2_e) ? l2_g - l2_e : '0;
      // weighted magnitudes
      p_slope_ff <= p_slope_in;
      p_hump_ff  <= p_hump_in;
      p_hump2_ff <= p_hump2_in;
      n_slope_ff <= slope_beta_ff[W-1];
      n_hump_ff  <= hump_beta_ff[W-1];
      n_hump2_ff <= second_hump_beta_ff[W-1];
      // exact sum, then clip
      sum_ff     <= sum_in;
      rate_ff    <= rate_in;
      sat_ff     <= sat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rate      = rate_ff;
   assign rsp_saturated = sat_ff;

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      l1_valid == l2_valid)
      else $error("top: tau lanes out of step");

   a_sat_at_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> (rsp_rate == RATE_MAX || rsp_rate == RATE_MIN))
      else $error("top: saturation flag without a clipped rate");

endmodule

### verif/svensson_rate_checker.sv
// Checker for the Svensson yield-curve evaluator: tracks CSR writes, predicts each rate beat
// and compares it with the response channel. Depends on ycs_pkg for widths and CSR indices.
module svensson_rate_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic [ycs_pkg::WORD_BITS-1:0]        req_maturity,
   input  logic                                 rsp_valid,
   input  logic signed [ycs_pkg::WORD_BITS-1:0] rsp_rate,
   input  logic                                 rsp_saturated,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [ycs_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [ycs_pkg::WORD_BITS-1:0]        csr_wdata,
   output int                                   fail_count,
   output int                                   outstanding
);

   typedef struct {
      logic signed [ycs_pkg::WORD_BITS-1:0] rate;
      logic                                 sat;
   } curve_point_type;

   localparam longint unsigned UNIT_Q31 = 64'd1 << ycs_pkg::INT_FRAC;

   curve_point_type     rate_queue[$];
   longint signed       beta_lvl, beta_slope, beta_hump, beta_hump2;
   longint unsigned     tau_a, tau_b;

   // floor(num * 2^bits / den) by restoring long division
   function automatic longint unsigned frac_divide(longint unsigned num, longint unsigned den,
                                                   int bits);
      longint unsigned q, r;
      q = num / den;
      r = num % den;
      for (int i = 0; i < bits; i++) begin
         q = q << 1;
         r = r << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 64'd1;
         end
      end
      return q;
   endfunction

   // exp(-f), f in Q31, truncated Taylor series clamped to [0, 1.0]
   function automatic longint unsigned decay_series(longint unsigned f);
      longint unsigned term;
      longint signed   acc;
      term = UNIT_Q31;
      acc  = longint'(UNIT_Q31);
      for (int k = 1; k < ycs_pkg::SERIES_TERMS; k++) begin
         term = ((term * f) >> ycs_pkg::INT_FRAC) / longint'(k);
         if (k % 2 == 1) acc = acc - longint'(term);
         else            acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > longint'(UNIT_Q31)) acc = longint'(UNIT_Q31);
      return longint'(acc);
   endfunction

   function automatic void tau_loadings(input longint unsigned t, input longint unsigned tau,
                                        output longint unsigned e, output longint unsigned g);
      longint unsigned xq, n, e_one;
      if (tau == 0) begin
         e = 0;
         g = 0;
      end else if (t >= (tau << ycs_pkg::X_CAP_SHIFT)) begin
         e = 0;
         g = frac_divide(tau, t, ycs_pkg::INT_FRAC);
      end else begin
         xq = frac_divide(t, tau, ycs_pkg::FRAC_BITS);
         if (xq == 0) begin
            // ratio below one lsb: use the limit
            e = UNIT_Q31;
            g = UNIT_Q31;
         end else begin
            n     = xq >> ycs_pkg::FRAC_BITS;
            e     = decay_series((xq & ((64'd1 << ycs_pkg::FRAC_BITS) - 1))
                                 << (ycs_pkg::INT_FRAC - ycs_pkg::FRAC_BITS));
            e_one = decay_series(UNIT_Q31);
            for (longint unsigned i = 0; i < n; i++) e = (e * e_one) >> ycs_pkg::INT_FRAC;
            g = ((UNIT_Q31 - e) << ycs_pkg::FRAC_BITS) / xq;
            if (g > UNIT_Q31) g = UNIT_Q31;
         end
      end
   endfunction

   // beta * loading / 2^31, truncated toward zero
   function automatic longint signed weigh(longint signed beta, longint unsigned f);
      longint unsigned mag, hi, lo, q, res;
      mag = (beta < 0) ? longint'(-beta) : longint'(beta);
      hi  = mag >> 24;
      lo  = mag & 64'hFF_FFFF;
      q   = hi * f;
      res = ((q >> ycs_pkg::INT_FRAC) << 24)
          + ((((q & (UNIT_Q31 - 1)) << 24) + lo * f) >> ycs_pkg::INT_FRAC);
      return (beta < 0) ? -longint'(res) : longint'(res);
   endfunction

   function automatic curve_point_type curve_rate(longint unsigned t);
      longint unsigned e1, g1, e2, g2, c1, c2;
      longint signed   total, top_lim;
      curve_point_type p;
      tau_loadings(t, tau_a, e1, g1);
      tau_loadings(t, tau_b, e2, g2);
      c1 = (g1 > e1) ? g1 - e1 : 0;
      c2 = (g2 > e2) ? g2 - e2 : 0;
      total = beta_lvl + weigh(beta_slope, g1) + weigh(beta_hump, c1)
            + weigh(beta_hump2, c2);
      top_lim = (64'sd1 <<< (ycs_pkg::WORD_BITS - 1)) - 1;
      p.sat = 1'b0;
      if (total > top_lim) begin
         total = top_lim;
         p.sat = 1'b1;
      end else if (total < -top_lim - 1) begin
         total = -top_lim - 1;
         p.sat = 1'b1;
      end
      p.rate = total[ycs_pkg::WORD_BITS-1:0];
      return p;
   endfunction

   assign outstanding = rate_queue.size();

   always @(posedge clock) begin
      curve_point_type want;
      if (reset) begin
         beta_lvl   = 0;
         beta_slope = 0;
         beta_hump  = 0;
         beta_hump2 = 0;
         tau_a      = ycs_pkg::DECAY_RESET;
         tau_b      = ycs_pkg::DECAY_RESET;
         rate_queue.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid) begin
            if (rate_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected rate beat: rate=%0d sat=%0b", rsp_rate, rsp_saturated);
            end else begin
               want = rate_queue.pop_front();
               if (want.rate !== rsp_rate || want.sat !== rsp_saturated) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("rate mismatch: expected rate=%0d sat=%0b, got rate=%0d sat=%0b",
                              want.rate, want.sat, rsp_rate, rsp_saturated);
               end
            end
         end
         // beat accepted: predict against the CSRs in force now
         if (start && !busy) rate_queue.push_back(curve_rate(req_maturity));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ycs_pkg::CSR_LEVEL:  beta_lvl   = longint'($signed(csr_wdata));
               ycs_pkg::CSR_SLOPE:  beta_slope = longint'($signed(csr_wdata));
               ycs_pkg::CSR_HUMP:   beta_hump  = longint'($signed(csr_wdata));
               ycs_pkg::CSR_HUMP2:  beta_hump2 = longint'($signed(csr_wdata));
               ycs_pkg::CSR_DECAY1: tau_a      = csr_wdata;
               ycs_pkg::CSR_DECAY2: tau_b      = csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

### verif/yield_curve_svensson_eval_top_tb.sv
// Testbench top for the Svensson yield-curve evaluator: clock, reset, CSR phases and maturity
// stimulus. Depends on ycs_pkg, the rtl/ sources and verif/svensson_rate_checker.sv.
module yield_curve_svensson_eval_top_tb;

   // indices with no register behind them; writes must be dropped
   localparam logic [ycs_pkg::CSR_IDX_BITS-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [ycs_pkg::CSR_IDX_BITS-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic [ycs_pkg::WORD_BITS-1:0]    ONE_YEAR     = 32'h0100_0000;
   localparam int                               DRAIN_CYCLES = 300;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 start = 1'b0;
   logic                                 busy;
   logic [ycs_pkg::WORD_BITS-1:0]        req_maturity = '0;
   logic                                 rsp_valid;
   logic signed [ycs_pkg::WORD_BITS-1:0] rsp_rate;
   logic                                 rsp_saturated;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [ycs_pkg::CSR_IDX_BITS-1:0]     csr_index = '0;
   logic [ycs_pkg::WORD_BITS-1:0]        csr_wdata = '0;
   int                                   fail_count;
   int                                   outstanding;

   // taus as last written, so maturities can be aimed at each lane's regions
   logic [ycs_pkg::WORD_BITS-1:0] tau_one = ycs_pkg::DECAY_RESET;
   logic [ycs_pkg::WORD_BITS-1:0] tau_two = ycs_pkg::DECAY_RESET;
   int                            idle_pct = 0;

   always #2 clock = ~clock;

   yield_curve_svensson_eval_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_maturity(req_maturity), .rsp_valid(rsp_valid), .rsp_rate(rsp_rate),
      .rsp_saturated(rsp_saturated), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   svensson_rate_checker rate_check (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_maturity(req_maturity), .rsp_valid(rsp_valid), .rsp_rate(rsp_rate),
      .rsp_saturated(rsp_saturated), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata), .fail_count(fail_count),
      .outstanding(outstanding)
   );

   // one CSR beat; held until ready is seen at an edge
   task automatic csr_write(input logic [ycs_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [ycs_pkg::WORD_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == ycs_pkg::CSR_DECAY1) tau_one = val;
      if (idx == ycs_pkg::CSR_DECAY2) tau_two = val;
   endtask

   task automatic load_curve(input logic [ycs_pkg::WORD_BITS-1:0] b0,
                             input logic [ycs_pkg::WORD_BITS-1:0] b1,
                             input logic [ycs_pkg::WORD_BITS-1:0] b2,
                             input logic [ycs_pkg::WORD_BITS-1:0] b3,
                             input logic [ycs_pkg::WORD_BITS-1:0] t1,
                             input logic [ycs_pkg::WORD_BITS-1:0] t2);
      // CSRs only change with nothing in flight
      while (outstanding != 0) @(posedge clock);
      csr_write(ycs_pkg::CSR_LEVEL, b0);
      csr_write(ycs_pkg::CSR_SLOPE, b1);
      csr_write(ycs_pkg::CSR_HUMP, b2);
      csr_write(ycs_pkg::CSR_HUMP2, b3);
      csr_write(ycs_pkg::CSR_DECAY1, t1);
      csr_write(ycs_pkg::CSR_DECAY2, t2);
   endtask

   // one maturity beat, then a random gap as the idle phase asks
   task automatic send_maturity(input logic [ycs_pkg::WORD_BITS-1:0] t);
      start        <= 1'b1;
      req_maturity <= t;
      do @(posedge clock); while (busy);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // maturities aimed at the tiny, normal, near-cap and capped regions of a lane
   function automatic logic [ycs_pkg::WORD_BITS-1:0] pick_maturity(
         input logic [ycs_pkg::WORD_BITS-1:0] tau);
      longint unsigned cap;
      logic [ycs_pkg::WORD_BITS-1:0] t;
      cap = longint'(tau) << ycs_pkg::X_CAP_SHIFT;
      case ($urandom_range(9))
         0:       t = '0;
         1:       t = $urandom_range(tau >> ycs_pkg::FRAC_BITS);        // ratio below one lsb
         2, 3:    t = $urandom();
         4:       t = (cap > 32'hFFFF_FFFF) ? $urandom() :
                      ycs_pkg::WORD_BITS'(cap - 4 + $urandom_range(8));  // either side of cap
         default: t = (cap == 0) ? $urandom() :
                      ycs_pkg::WORD_BITS'($urandom() %
                         ((cap > 32'hFFFF_FFFF) ? 64'h1_0000_0000 : cap));
      endcase
      return t;
   endfunction

   function automatic logic [ycs_pkg::WORD_BITS-1:0] pick_tau();
      case ($urandom_range(7))
         0:       return '0;                                            // zero tau
         1:       return $urandom();
         2:       return $urandom_range(1, 255);
         default: return $urandom_range(ONE_YEAR >> 3, ONE_YEAR << 4);
      endcase
   endfunction

   initial begin
      #4_000_000;
      $display("yield_curve_svensson_eval_top verification failed");
      $finish;
   end

   initial begin
      logic [ycs_pkg::WORD_BITS-1:0] directed[$];
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // a few beats with reset CSRs: all zero betas give zero
      send_maturity('0);
      send_maturity(ONE_YEAR);
      start <= 1'b0;

      // directed: b0=1.5 b1=-0.5 b2=2 b3=-1, taus 1 and 3 years
      load_curve(32'h0180_0000, 32'hFF80_0000, 32'h0200_0000, 32'hFF00_0000,
                 ONE_YEAR, 3 * ONE_YEAR);
      csr_write(CSR_SPARE_LO, 32'hDEAD_BEEF);
      csr_write(CSR_SPARE_HI, 32'h1234_5678);
      directed = '{32'h0, 32'h1, 32'hFFFF_FFFF, ONE_YEAR, ONE_YEAR >> 1,
                   32 * ONE_YEAR - 1, 32 * ONE_YEAR, 96 * ONE_YEAR - 1, 96 * ONE_YEAR,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                   10 * ONE_YEAR + 32'h0080_0000};
      foreach (directed[i]) send_maturity(directed[i]);
      start <= 1'b0;

      // extremes: all betas max drives saturation high, smallest and largest taus
      load_curve(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h1, 32'hFFFF_FFFF);
      foreach (directed[i]) send_maturity(directed[i]);
      start <= 1'b0;
      // all betas min, one zero tau
      load_curve(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 '0, ONE_YEAR);
      foreach (directed[i]) send_maturity(directed[i]);
      start <= 1'b0;

      // random part: 16 curve settings across four idle phases
      for (int ph = 0; ph < 16; ph++) begin
         case (ph % 4)
            0: idle_pct = 0;
            1: idle_pct = 75;
            2: idle_pct = 0;     // receiver stall phase: nothing to stall
            3: idle_pct = 9;
         endcase
         load_curve($urandom(), $urandom(),
                    ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 32'h0400_0000),
                    ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 32'h0400_0000),
                    pick_tau(), pick_tau());
         for (int k = 0; k < 80; k++)
            send_maturity(pick_maturity(($urandom_range(1) == 0) ? tau_one : tau_two));
         start <= 1'b0;
      end

      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("yield_curve_svensson_eval_top verification clean");
      end else begin
         $display("yield_curve_svensson_eval_top verification failed");
      end
      $finish;
   end

endmodule
